// ===== rtl/srcu_pkg.sv =====
`default_nettype none
package srcu_pkg;

  localparam int CMD_BITS = 4;
  localparam int WS_BITS  = 7;
  localparam int CNT_BITS = 16;
  localparam int JC_BITS  = 6;
  localparam int OPW      = 64;

  localparam logic [CMD_BITS-1:0] CMD_ASR    = 4'd0;
  localparam logic [CMD_BITS-1:0] CMD_SHL    = 4'd1;
  localparam logic [CMD_BITS-1:0] CMD_SHR    = 4'd2;
  localparam logic [CMD_BITS-1:0] CMD_ROL    = 4'd3;
  localparam logic [CMD_BITS-1:0] CMD_ROR    = 4'd4;
  localparam logic [CMD_BITS-1:0] CMD_ROLC   = 4'd5;
  localparam logic [CMD_BITS-1:0] CMD_RORC   = 4'd6;
  localparam logic [CMD_BITS-1:0] CMD_LJUST  = 4'd7;
  localparam logic [CMD_BITS-1:0] CMD_RJUST  = 4'd8;
  localparam logic [CMD_BITS-1:0] CMD_MIRROR = 4'd9;

  typedef struct packed {
    logic [CMD_BITS-1:0] cmd;
    logic                carry;
  } step_ctrl_t;

  typedef struct packed {
    logic                carry;
  } step_flag_t;

endpackage
`default_nettype wire

// ===== rtl/srcu_rem.sv =====
`default_nettype none
// restoring remainder, one dividend bit per cycle
module srcu_rem
  import srcu_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [CNT_BITS-1:0] dividend,
  input  wire logic [WS_BITS-1:0]  divisor,
  output logic                    done,
  output logic [WS_BITS-1:0]      rem
);

  localparam int SC_BITS = $clog2(CNT_BITS + 1);

  logic [CNT_BITS-1:0] dvd_r, dvd_nxt;
  logic [WS_BITS-1:0]  div_r, div_nxt;
  logic [WS_BITS-1:0]  rem_r, rem_nxt;
  logic [SC_BITS-1:0]  cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [WS_BITS:0]    trial;

  always_comb begin
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[CNT_BITS-1]};
    if (start) begin
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = SC_BITS'(CNT_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = WS_BITS'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[WS_BITS-1:0];
      end
      dvd_nxt = {dvd_r[CNT_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == SC_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

// ===== rtl/srcu_step.sv =====
`default_nettype none
// one single-bit step of the selected command
module srcu_step
  import srcu_pkg::*;
#(
  parameter int W = 64
) (
  input  wire step_ctrl_t           ctrl,
  input  wire logic [W-1:0]         word_in,
  input  wire logic [W-1:0]         mir_in,
  input  wire logic [W-1:0]         mask,
  input  wire logic [$clog2(W)-1:0] top,
  output logic [W-1:0]              word_out,
  output logic [W-1:0]              mir_out,
  output step_flag_t                flag
);

  logic [W-1:0] topbit;
  logic         lo, hi;

  assign topbit = W'(1) << top;
  assign lo     = word_in[0];
  assign hi     = word_in[top];

  always_comb begin
    word_out   = word_in;
    mir_out    = mir_in;
    flag.carry = ctrl.carry;
    case (ctrl.cmd)
      CMD_ASR: begin
        flag.carry = lo;
        word_out   = (word_in >> 1) | (hi ? topbit : '0);
      end
      CMD_SHL: begin
        flag.carry = hi;
        word_out   = (word_in << 1) & mask;
      end
      CMD_SHR: begin
        flag.carry = lo;
        word_out   = word_in >> 1;
      end
      CMD_ROL: begin
        flag.carry = hi;
        word_out   = ((word_in << 1) | W'(hi)) & mask;
      end
      CMD_ROR: begin
        flag.carry = lo;
        word_out   = (word_in >> 1) | (lo ? topbit : '0);
      end
      CMD_ROLC: begin
        flag.carry = hi;
        word_out   = ((word_in << 1) | W'(ctrl.carry)) & mask;
      end
      CMD_RORC: begin
        flag.carry = lo;
        word_out   = (word_in >> 1) | (ctrl.carry ? topbit : '0);
      end
      CMD_LJUST: begin
        word_out = (word_in << 1) & mask;
      end
      CMD_RJUST: begin
        word_out = word_in >> 1;
      end
      CMD_MIRROR: begin
        word_out = word_in >> 1;
        mir_out  = {mir_in[W-2:0], lo};
      end
      default: begin
        word_out = word_in;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/word_shift_rotate_carry_unit_core.sv =====
`default_nettype none
// channel | dir | handshake            | payload
// in_     | in  | in_tvalid/in_tready  | in_tdata: command, operand, shift_count, carry_in
// out_    | out | out_tvalid/out_tready| out_tdata: result_word, carry_out, justify_count
// cfg_    | in  | cfg_valid/cfg_ready  | cfg_data: word_size
// Work from accept to next accept, w the active word size: only the final write for a zero
// count, an undefined command or justify of zero; one step per place for a shift of n <= w+1;
// for a rotate, a remainder from srcu_rem and one handoff, then n <= w+1 steps; one step per
// place and a final check for a justify; w steps for mirror.
// Reset is synchronous, active low; word_size returns to 64.
// in_tready is low while an item is in work; a held result stalls only the final write.
module word_shift_rotate_carry_unit_core
  import srcu_pkg::*;
#(
  parameter int MAX_WORD_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [3:0] command, [67:4] operand, [83:68] shift_count, [84] carry_in, [87:85] zero
  input  wire logic [87:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [63:0] result_word, [64] carry_out, [70:65] justify_count, [71] zero
  output logic [71:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  cfg_data
);

  localparam int W  = MAX_WORD_BITS;
  localparam int IW = $clog2(W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_STEP = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [WS_BITS-1:0]  cfg_ws_r;
  logic [WS_BITS-1:0]  ws_eff;
  logic [W-1:0]        mask_now;
  logic [W-1:0]        x_in;
  logic [CMD_BITS-1:0] cmd_in;
  logic [CNT_BITS-1:0] n_in;

  logic [CMD_BITS-1:0] cmd_r, cmd_nxt;
  logic [W-1:0]        x_r, x_nxt;
  logic [W-1:0]        r_r, r_nxt;
  logic [W-1:0]        mask_r, mask_nxt;
  logic [IW-1:0]       top_r, top_nxt;
  logic                c_r, c_nxt;
  logic [WS_BITS-1:0]  cnt_r, cnt_nxt;
  logic [JC_BITS-1:0]  jc_r, jc_nxt;

  logic                out_valid_r;
  logic [71:0]         out_data_r;

  logic                div_start;
  logic [CNT_BITS-1:0] div_dvd;
  logic [WS_BITS-1:0]  div_dsr;
  logic                div_done;
  logic [WS_BITS-1:0]  div_rem;

  step_ctrl_t          sctrl;
  step_flag_t          sflag;
  logic [W-1:0]        sx, sr;
  logic                jdone;
  logic [W-1:0]        res_word;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);

  assign ws_eff = (cfg_ws_r == '0) ? WS_BITS'(1) :
                  ((cfg_ws_r > WS_BITS'(W)) ? WS_BITS'(W) : cfg_ws_r);

  always_comb begin
    for (int i = 0; i < W; i++) begin
      mask_now[i] = (WS_BITS'(i) < ws_eff);
    end
  end

  assign cmd_in = in_tdata[3:0];
  assign x_in   = in_tdata[4 +: W] & mask_now;
  assign n_in   = in_tdata[83:68];

  assign sctrl.cmd   = cmd_r;
  assign sctrl.carry = c_r;

  srcu_step #(.W(W)) u_step (
    .ctrl     (sctrl),
    .word_in  (x_r),
    .mir_in   (r_r),
    .mask     (mask_r),
    .top      (top_r),
    .word_out (sx),
    .mir_out  (sr),
    .flag     (sflag)
  );

  srcu_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign jdone = (cmd_r == CMD_LJUST) ? x_r[top_r] : x_r[0];
  assign res_word = ((cmd_r == CMD_MIRROR) ? r_r : x_r) & mask_r;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    x_nxt     = x_r;
    r_nxt     = r_r;
    mask_nxt  = mask_r;
    top_nxt   = top_r;
    c_nxt     = c_r;
    cnt_nxt   = cnt_r;
    jc_nxt    = jc_r;
    div_start = 1'b0;
    div_dvd   = n_in - 1'b1;
    div_dsr   = ws_eff;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = cmd_in;
          x_nxt     = x_in;
          r_nxt     = '0;
          mask_nxt  = mask_now;
          top_nxt   = IW'(ws_eff - 1'b1);
          c_nxt     = in_tdata[84];
          jc_nxt    = '0;
          state_nxt = ST_DONE;
          case (cmd_in)
            CMD_ASR, CMD_SHL, CMD_SHR: begin
              if (n_in != '0) begin
                cnt_nxt   = (n_in > CNT_BITS'(ws_eff) + 1'b1) ? ws_eff + 1'b1
                                                             : n_in[WS_BITS-1:0];
                state_nxt = ST_STEP;
              end
            end
            CMD_ROL, CMD_ROR, CMD_ROLC, CMD_RORC: begin
              if (n_in != '0) begin
                div_start = 1'b1;
                if (cmd_in == CMD_ROLC || cmd_in == CMD_RORC) begin
                  div_dsr = ws_eff + 1'b1;
                end
                state_nxt = ST_DIV;
              end
            end
            CMD_LJUST, CMD_RJUST: begin
              if (x_in != '0) begin
                state_nxt = ST_STEP;
              end
            end
            CMD_MIRROR: begin
              cnt_nxt   = ws_eff;
              state_nxt = ST_STEP;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          cnt_nxt   = div_rem + 1'b1;
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (cmd_r == CMD_LJUST || cmd_r == CMD_RJUST) begin
          if (jdone) begin
            state_nxt = ST_DONE;
          end else begin
            x_nxt  = sx;
            jc_nxt = jc_r + 1'b1;
          end
        end else begin
          x_nxt   = sx;
          r_nxt   = sr;
          c_nxt   = sflag.carry;
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == WS_BITS'(1)) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    x_r    <= x_nxt;
    r_r    <= r_nxt;
    mask_r <= mask_nxt;
    top_r  <= top_nxt;
    c_r    <= c_nxt;
    cnt_r  <= cnt_nxt;
    jc_r   <= jc_nxt;
    if (state_r == ST_DONE && (!out_valid_r || out_tready)) begin
      out_data_r <= {1'b0, jc_r, c_r, OPW'(res_word)};
    end
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_ws_r    <= WS_BITS'(64);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        cfg_ws_r <= cfg_data;
      end
      if (state_r == ST_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
module tb;
  import srcu_pkg::*;

  localparam logic [CMD_BITS-1:0] CMD_TOP_CODE = '1;
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 100;

  typedef struct packed {
    logic [CMD_BITS-1:0] cmd;
    logic [OPW-1:0]      operand;
    logic [CNT_BITS-1:0] count;
    logic                cin;
  } shift_req_t;

  typedef struct packed {
    logic [OPW-1:0]     word;
    logic               cout;
    logic [JC_BITS-1:0] jcnt;
  } shift_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;

  shift_req_t cmd_backlog[$];
  shift_res_t due_words[$];
  shift_req_t req_on_bus;
  logic [6:0] ws_now = 7'd64;
  int n_queued = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_errors = 0;
  int in_gap = 0;
  int out_gap = 0;
  int in_odds = 0;
  int out_odds = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  word_shift_rotate_carry_unit_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  function automatic int active_bits(logic [6:0] ws);
    int w;
    w = ws;
    if (w < 1) w = 1;
    if (w > OPW) w = OPW;
    return w;
  endfunction

  function automatic shift_res_t shift_rotate_word(shift_req_t r, logic [6:0] ws);
    shift_res_t res;
    int w;
    int top;
    int n;
    int j;
    logic [OPW-1:0] m;
    logic [OPW-1:0] x;
    logic [OPW-1:0] mir;
    logic c;
    logic lo;
    logic hi;
    logic sgn;
    w = active_bits(ws);
    top = w - 1;
    m = (w == OPW) ? '1 : ((64'd1 << w) - 64'd1);
    x = r.operand & m;
    n = r.count;
    c = r.cin;
    sgn = x[top];
    j = 0;
    case (r.cmd)
      CMD_ASR, CMD_SHL, CMD_SHR: if (n > w + 1) n = w + 1;
      CMD_ROL, CMD_ROR:          if (n > 0) n = (n - 1) % w + 1;
      CMD_ROLC, CMD_RORC:        if (n > 0) n = (n - 1) % (w + 1) + 1;
      default:                   n = 0;
    endcase
    for (int i = 0; i < n; i++) begin
      lo = x[0];
      hi = x[top];
      case (r.cmd)
        CMD_ASR: begin
          c = lo;
          x = x >> 1;
          x[top] = sgn;
        end
        CMD_SHL: begin
          c = hi;
          x = (x << 1) & m;
        end
        CMD_SHR: begin
          c = lo;
          x = x >> 1;
        end
        CMD_ROL: begin
          c = hi;
          x = ((x << 1) | OPW'(hi)) & m;
        end
        CMD_ROR: begin
          c = lo;
          x = x >> 1;
          x[top] = lo;
        end
        CMD_ROLC: begin
          x = ((x << 1) | OPW'(c)) & m;
          c = hi;
        end
        default: begin
          x = x >> 1;
          x[top] = c;
          c = lo;
        end
      endcase
    end
    if (r.cmd == CMD_LJUST && x != '0) begin
      while (!x[top]) begin
        x = (x << 1) & m;
        j++;
      end
    end else if (r.cmd == CMD_RJUST && x != '0) begin
      while (!x[0]) begin
        x = x >> 1;
        j++;
      end
    end else if (r.cmd == CMD_MIRROR) begin
      mir = '0;
      for (int i = 0; i < w; i++)
        if (x[i]) mir[w-1-i] = 1'b1;
      x = mir;
    end
    res.word = x & m;
    res.cout = c;
    res.jcnt = JC_BITS'(j);
    return res;
  endfunction

  function automatic void queue_cmd(logic [CMD_BITS-1:0] cmd, logic [OPW-1:0] op,
                                    logic [CNT_BITS-1:0] cnt, logic cin);
    shift_req_t r;
    r.cmd = cmd;
    r.operand = op;
    r.count = cnt;
    r.cin = cin;
    cmd_backlog.push_back(r);
    n_queued++;
  endfunction

  function automatic void queue_random_cmd(int w);
    logic [CMD_BITS-1:0] cmd;
    logic [OPW-1:0] op;
    int cnt;
    int pick;
    pick = $urandom_range(0, 31);
    if (pick < 30) cmd = CMD_BITS'(pick % (CMD_MIRROR + 1));
    else cmd = CMD_BITS'($urandom_range(CMD_MIRROR + 1, CMD_TOP_CODE));
    case ($urandom_range(0, 7))
      0: op = '0;
      1: op = '1;
      2: op = 64'd1 << $urandom_range(0, OPW - 1);
      3: op = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      4: op = {$urandom, $urandom} | (64'd1 << (w - 1));
      default: op = {$urandom, $urandom};
    endcase
    case ($urandom_range(0, 7))
      0: cnt = 0;
      1: cnt = 1;
      2: cnt = $urandom_range(0, 2 * w + 3);
      3: cnt = $urandom_range(1, 8) * (w + $urandom_range(0, 1)) + $urandom_range(0, 2) - 1;
      4: cnt = $urandom_range(0, 65535);
      5: cnt = 65535;
      default: cnt = $urandom_range(0, w + 2);
    endcase
    queue_cmd(cmd, op, CNT_BITS'(cnt), 1'($urandom_range(0, 1)));
  endfunction

  task automatic wait_all_done();
    while (n_accepted != n_queued || n_results != n_accepted) @(posedge clk);
  endtask

  task automatic write_word_size(logic [6:0] v);
    @(posedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    ws_now = v;
    cfg_valid <= 1'b0;
  endtask

  // driver
  always @(posedge clk) begin : drive_in
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        due_words.push_back(shift_rotate_word(req_on_bus, ws_now));
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (cmd_backlog.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (in_odds > 0 && $urandom_range(0, 7) < in_odds) begin
          in_gap = $urandom_range(0, 2);
          in_tvalid <= 1'b0;
        end else begin
          req_on_bus = cmd_backlog.pop_front();
          in_tdata <= {3'b000, req_on_bus.cin, req_on_bus.count, req_on_bus.operand,
                       req_on_bus.cmd};
          in_tvalid <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch_out
    shift_res_t got;
    shift_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.word = out_tdata[63:0];
      got.cout = out_tdata[64];
      got.jcnt = out_tdata[70:65];
      n_results++;
      if (due_words.size() == 0) begin
        $error("unexpected item: word=%h carry=%b jcount=%0d", got.word, got.cout, got.jcnt);
        n_errors++;
      end else begin
        want = due_words.pop_front();
        if (got.word !== want.word) begin
          $error("result_word: expected %h, got %h", want.word, got.word);
          n_errors++;
        end
        if (got.cout !== want.cout) begin
          $error("carry_out: expected %b, got %b", want.cout, got.cout);
          n_errors++;
        end
        if (got.jcnt !== want.jcnt) begin
          $error("justify_count: expected %0d, got %0d", want.jcnt, got.jcnt);
          n_errors++;
        end
      end
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else if (out_odds > 0 && $urandom_range(0, 7) < out_odds) begin
      out_gap = $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog: cycles with no handshake anywhere
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [6:0] ws_plan[11] = '{7'd1, 7'd0, 7'd127, 7'd64, 7'd65, 7'd63, 7'd8, 7'd2,
                                7'd16, 7'd32, 7'd33};
    logic [6:0] ws;
    int phases;
    phases = 14;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    in_odds = 2;
    out_odds = 2;

    // directed, word size at reset value
    queue_cmd(CMD_ASR,    64'h8000_0000_0000_0001, 16'd1,     1'b0);
    queue_cmd(CMD_ASR,    64'h8000_0000_0000_0001, 16'd0,     1'b1);
    queue_cmd(CMD_ASR,    64'h8000_0000_0000_0000, 16'd65535, 1'b0);
    queue_cmd(CMD_SHL,    '1,                      16'd1,     1'b0);
    queue_cmd(CMD_SHL,    '1,                      16'd64,    1'b0);
    queue_cmd(CMD_SHL,    '1,                      16'd65,    1'b1);
    queue_cmd(CMD_SHR,    '1,                      16'd64,    1'b0);
    queue_cmd(CMD_SHR,    '1,                      16'd65535, 1'b1);
    queue_cmd(CMD_ROL,    64'h8000_0000_0000_0001, 16'd1,     1'b0);
    queue_cmd(CMD_ROL,    64'h8000_0000_0000_0001, 16'd64,    1'b1);
    queue_cmd(CMD_ROL,    64'h0123_4567_89AB_CDEF, 16'd65535, 1'b0);
    queue_cmd(CMD_ROR,    64'h0000_0000_0000_0001, 16'd1,     1'b0);
    queue_cmd(CMD_ROR,    64'h0123_4567_89AB_CDEF, 16'd65,    1'b1);
    queue_cmd(CMD_ROLC,   '1,                      16'd65,    1'b0);
    queue_cmd(CMD_ROLC,   64'h8000_0000_0000_0000, 16'd1,     1'b1);
    queue_cmd(CMD_ROLC,   64'h0123_4567_89AB_CDEF, 16'd65535, 1'b1);
    queue_cmd(CMD_RORC,   64'h0000_0000_0000_0001, 16'd1,     1'b1);
    queue_cmd(CMD_RORC,   64'h0123_4567_89AB_CDEF, 16'd66,    1'b0);
    queue_cmd(CMD_LJUST,  '0,                      16'd0,     1'b1);
    queue_cmd(CMD_LJUST,  64'h0000_0000_0000_0001, 16'd0,     1'b0);
    queue_cmd(CMD_RJUST,  '0,                      16'd7,     1'b0);
    queue_cmd(CMD_RJUST,  64'h8000_0000_0000_0000, 16'd0,     1'b1);
    queue_cmd(CMD_MIRROR, 64'h0123_4567_89AB_CDEF, 16'd3,     1'b1);
    queue_cmd(CMD_BITS'(CMD_MIRROR + 1), '1,       16'd5,     1'b1);
    queue_cmd(CMD_TOP_CODE,   '1,                  16'd0,     1'b0);
    wait_all_done();

    // random phases, one word size each; sender holds off between them
    for (int ph = 0; ph < phases; ph++) begin
      if (ph == phases - 1) begin
        ws = 7'd64;
        in_odds = 0;
        out_odds = 0;
      end else begin
        ws = (ph < $size(ws_plan)) ? ws_plan[ph] : 7'($urandom_range(0, 127));
        in_odds = $urandom_range(0, 3);
        out_odds = $urandom_range(0, 3);
      end
      write_word_size(ws);
      for (int k = 0; k < 100; k++) queue_random_cmd(active_bits(ws));
      wait_all_done();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_errors == 0 && due_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/srcu_pkg.sv
rtl/srcu_rem.sv
rtl/srcu_step.sv
rtl/word_shift_rotate_carry_unit_core.sv
sim/tb.sv
